/* rtl/rcsfd_pkg.sv */
// Shared types, constants and scale table for the serial RC frame decoder.
package rcsfd_pkg;

  localparam int FRAME_LEN = 25;
  localparam int NUM_CH    = 16;
  localparam int SCALED_CH = 9;
  localparam int RAW_W     = 11;
  localparam int MAG_W     = 19;
  localparam int SCL_W     = 9;
  localparam int REC_W     = 20;
  localparam int REC_SHIFT = 30;
  localparam int CH_BITS   = NUM_CH * RAW_W;
  localparam int TDATA_W   = 32;

  localparam logic [7:0] HEADER_BYTE = 8'h0F;
  localparam logic [7:0] FOOTER_BYTE = 8'h00;
  localparam int LOST_BIT     = 2;
  localparam int FAILSAFE_BIT = 3;

  localparam logic [4:0] POS_CH_LAST = 5'd22;
  localparam logic [4:0] POS_FLAGS   = 5'd23;
  localparam logic [4:0] POS_LAST    = 5'(FRAME_LEN - 1);
  localparam logic [4:0] POS_DONE    = 5'(FRAME_LEN);
  localparam logic [3:0] CH_LAST     = 4'(NUM_CH - 1);
  localparam logic [3:0] CH_SCL_LAST = 4'(SCALED_CH - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_OUT,
    ST_BAD
  } state_t;

  typedef enum logic [1:0] {
    SEL_NONE,
    SEL_HEADER,
    SEL_CHAN,
    SEL_FLAGS
  } store_sel_t;

  typedef struct packed {
    store_sel_t store_sel;
    logic       mul_en;
    logic       div_step;
    logic       load_out;
    logic       load_bad;
    logic [3:0] ch;
  } cmd_t;

  typedef struct packed {
    logic hdr_ok;
    logic ftr_ok;
    logic out_free;
  } sts_t;

  // recip = ceil(2^REC_SHIFT / (in_hi - in_lo)), exact floor for every product
  typedef struct packed {
    logic [10:0]       in_lo;
    logic [7:0]        out_span;
    logic signed [8:0] out_lo;
    logic [REC_W-1:0]  recip;
  } scale_t;

  function automatic scale_t scale_lookup(logic [3:0] ch);
    scale_t s;
    s = '0;
    case (ch)
      4'd0:    s = '{11'd314, 8'd40,  -9'sd20,  20'd780336};
      4'd1:    s = '{11'd306, 8'd200, -9'sd100, 20'd774147};
      4'd2:    s = '{11'd306, 8'd230, -9'sd115, 20'd774147};
      4'd3:    s = '{11'd302, 8'd200, -9'sd100, 20'd771367};
      4'd4:    s = '{11'd306, 8'd100, 9'sd0,    20'd773590};
      4'd5:    s = '{11'd306, 8'd100, -9'sd50,  20'd773590};
      4'd6:    s = '{11'd306, 8'd100, 9'sd0,    20'd773590};
      4'd7:    s = '{11'd306, 8'd100, 9'sd0,    20'd773590};
      4'd8:    s = '{11'd292, 8'd100, 9'sd0,    20'd766959};
      default: s = '{11'd0,   8'd0,   9'sd0,    20'd0};
    endcase
    return s;
  endfunction

endpackage

/* rtl/rcsfd_ctrl.sv */
// Controller: byte position tracking, frame check and per-channel sequencing.
module rcsfd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_start,
  output logic          in_ready,
  input  rcsfd_pkg::sts_t sts,
  output rcsfd_pkg::cmd_t cmd
);
  import rcsfd_pkg::*;

  state_t     state, state_next;
  logic [4:0] pos, pos_next;
  logic [3:0] ch, ch_next;
  logic [4:0] eff_pos;
  logic       accept;

  assign eff_pos = in_start ? 5'd0 : pos;
  assign accept  = in_valid && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pos   <= '0;
      ch    <= '0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
      ch    <= ch_next;
    end
  end

  always_comb begin
    state_next = state;
    pos_next   = pos;
    ch_next    = ch;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (eff_pos < POS_DONE) begin
            pos_next = eff_pos + 5'd1;
            if (eff_pos == POS_LAST) begin
              ch_next    = '0;
              state_next = (sts.hdr_ok && sts.ftr_ok) ? ST_MUL : ST_BAD;
            end
          end else begin
            pos_next = eff_pos;
          end
        end
      end
      ST_MUL: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          if (ch == CH_LAST) begin
            state_next = ST_IDLE;
          end else begin
            ch_next    = ch + 4'd1;
            state_next = (ch < CH_SCL_LAST) ? ST_MUL : ST_OUT;
          end
        end
      end
      ST_BAD: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.store_sel = SEL_NONE;
    cmd.ch        = ch;
    in_ready      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          if (eff_pos == 5'd0)              cmd.store_sel = SEL_HEADER;
          else if (eff_pos <= POS_CH_LAST)  cmd.store_sel = SEL_CHAN;
          else if (eff_pos == POS_FLAGS)    cmd.store_sel = SEL_FLAGS;
        end
      end
      ST_MUL:  cmd.mul_en   = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_OUT:  cmd.load_out = sts.out_free;
      ST_BAD:  cmd.load_bad = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

/* rtl/rcsfd_dpath.sv */
// Datapath: frame bytes, channel unpacking, reciprocal scaling and output register.
module rcsfd_dpath (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [7:0]                in_byte,
  input  rcsfd_pkg::cmd_t           cmd,
  output rcsfd_pkg::sts_t           sts,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [rcsfd_pkg::TDATA_W-1:0] out_data,
  output logic                      out_last
);
  import rcsfd_pkg::*;

  logic [7:0]         header;
  logic [7:0]         flags;
  logic [CH_BITS-1:0] chan_sr;
  logic               neg;
  logic [MAG_W-1:0]   mag;
  logic [SCL_W-1:0]   quo;

  logic [3:0]         o_ch;
  logic [RAW_W-1:0]   o_raw;
  logic [SCL_W-1:0]   o_scaled;
  logic               o_lost, o_fs, o_ok;

  scale_t                 sp;
  logic [RAW_W-1:0]       raw;
  logic signed [11:0]     diff;
  logic [RAW_W-1:0]       diff_mag;
  logic [MAG_W-1:0]       prod;
  logic [MAG_W+REC_W-1:0] qprod;
  logic signed [9:0]      q_s;
  logic signed [9:0]      sum;

  assign sp       = scale_lookup(cmd.ch);
  assign raw      = chan_sr[RAW_W-1:0];
  assign diff     = $signed({1'b0, raw}) - $signed({1'b0, sp.in_lo});
  assign diff_mag = diff[11] ? RAW_W'(-diff) : diff[RAW_W-1:0];
  assign prod     = MAG_W'({8'd0, diff_mag} * {11'd0, sp.out_span});
  assign qprod    = {{REC_W{1'b0}}, mag} * {{MAG_W{1'b0}}, sp.recip};
  assign q_s      = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign sum      = q_s + 10'(sp.out_lo);

  assign sts.hdr_ok   = (header == HEADER_BYTE);
  assign sts.ftr_ok   = (in_byte == FOOTER_BYTE);
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    unique case (cmd.store_sel)
      SEL_HEADER: header  <= in_byte;
      SEL_CHAN:   chan_sr <= {in_byte, chan_sr[CH_BITS-1:8]};
      SEL_FLAGS:  flags   <= in_byte;
      SEL_NONE:   ;
      default:    ;
    endcase
    if (cmd.load_out) chan_sr <= {{RAW_W{1'b0}}, chan_sr[CH_BITS-1:RAW_W]};
    if (cmd.mul_en) begin
      neg <= diff[11];
      mag <= prod;
    end else if (cmd.div_step) begin
      quo <= qprod[REC_SHIFT +: SCL_W];
    end
    if (cmd.load_out) begin
      o_ch     <= cmd.ch;
      o_raw    <= raw;
      o_scaled <= (cmd.ch <= CH_SCL_LAST) ? sum[SCL_W-1:0] : '0;
      o_lost   <= flags[LOST_BIT];
      o_fs     <= flags[FAILSAFE_BIT];
      o_ok     <= 1'b1;
      out_last <= (cmd.ch == CH_LAST);
    end else if (cmd.load_bad) begin
      o_ch     <= '0;
      o_raw    <= '0;
      o_scaled <= '0;
      o_lost   <= 1'b0;
      o_fs     <= 1'b0;
      o_ok     <= 1'b0;
      out_last <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out || cmd.load_bad) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out_data = {5'd0, o_ok, o_fs, o_lost, o_scaled, o_raw, o_ch};

endmodule

/* rtl/rc_serial_frame_decoder_unit.sv */
// Top level of the serial RC frame decoder.
// Input stream: one frame byte per word, tuser marks byte 0 of a frame.
// Bytes 0..23 are stored; on byte 24 header (0x0F) and footer (0x00) are checked.
// A bad frame yields one output word with frame_ok 0 and tlast set.
// A good frame yields 16 words, channel 0..15 in order, tlast on channel 15,
// each with the 11-bit raw value, scaled value and the two flags of byte 23.
// Bytes after byte 24 without a start marker are dropped.
// Sequencing: channels 0..8 each pass through multiply, reciprocal multiply
// and output load; channels 9..15 go straight to output load, and a bad
// frame goes through a single bad-word load.
// s_axis_tready is low while a frame is being emitted; results sit in an
// output register, so the last word of a frame may still wait while the
// next bytes are taken. A stalled m_axis_tready holds the word and the
// sequencing behind it. Synchronous reset clears byte position, sequencer
// and output valid; the stored frame bytes are not cleared.
module rc_serial_frame_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
  input  logic        s_axis_tuser,   // [0] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [3:0] channel_index, [14:4] raw_value,
                                      // [23:15] scaled_value, [24] lost_frame,
                                      // [25] failsafe, [26] frame_ok, [31:27] zero
  output logic        m_axis_tlast    // last
);
  import rcsfd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rcsfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_start (s_axis_tuser),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rcsfd_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (s_axis_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

/* rtl/rcsfd_checker.sv */
// Port-level assertions for the serial RC frame decoder, bound to the top level.
module rcsfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  import rcsfd_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  a_bad_frame: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[26] |->
      m_axis_tlast && (m_axis_tdata[25:0] == 26'd0))
    else $error("bad frame word malformed");

  a_last_ch: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[26] |->
      (m_axis_tlast == (m_axis_tdata[3:0] == CH_LAST)))
    else $error("tlast not on final channel");

  a_unscaled: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[26] && (m_axis_tdata[3:0] > CH_SCL_LAST) |->
      (m_axis_tdata[23:15] == 9'd0))
    else $error("unscaled channel has nonzero scaled value");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[31:27] == 5'd0))
    else $error("pad bits set");

endmodule

bind rc_serial_frame_decoder_unit rcsfd_checker u_rcsfd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

/* tb/rc_serial_frame_decoder_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the serial RC frame decoder: frame stimulus, channel prediction.
module rc_serial_frame_decoder_unit_tb;
  import rcsfd_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 400;
  localparam int PHASE_ITEMS    = 25;
  localparam int PAYLOAD_BYTES  = 22;
  localparam int FLAGS_POS      = FRAME_LEN - 2;

  typedef struct packed {
    logic [3:0]        ch;
    logic [10:0]       raw;
    logic signed [8:0] scaled;
    logic              lost;
    logic              fs;
    logic              ok;
    logic              last;
  } chan_word_t;

  typedef struct {
    logic [7:0]  hdr;
    logic [7:0]  ftr;
    logic [7:0]  flags;
    logic [7:0]  fill;
    bit          rand_fill;
    int unsigned len;
    bit          first_start;
    int unsigned trail;
    bit          typed_bad;
  } frame_row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] frame_byte
  logic        s_axis_tuser;   // [0] frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [3:0] channel_index, [14:4] raw_value, [23:15] scaled_value,
                               // [24] lost_frame, [25] failsafe, [26] frame_ok
  logic        m_axis_tlast;   // last

  rc_serial_frame_decoder_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // hdr, ftr, flags, fill, rand_fill, len, first_start, trail, typed_bad
  frame_row_t dir_rows [6] = '{
    '{8'h0F, 8'h00, 8'h00, 8'h00, 1'b0, 25, 1'b0, 0, 1'b0},  // no start marker after reset
    '{8'h0F, 8'h00, 8'h0C, 8'hFF, 1'b0, 25, 1'b1, 0, 1'b0},  // all ones, both flags
    '{8'h0F, 8'h00, 8'h04, 8'hAA, 1'b0, 25, 1'b1, 2, 1'b0},  // lost frame, bytes past end
    '{8'h0F, 8'h00, 8'hF3, 8'h00, 1'b0, 9,  1'b1, 0, 1'b0},  // cut short
    '{8'h0E, 8'h00, 8'h00, 8'h00, 1'b1, 25, 1'b1, 0, 1'b1},  // restart mid-frame, bad header
    '{8'h0F, 8'h01, 8'h00, 8'h00, 1'b1, 25, 1'b1, 0, 1'b1}   // bad footer
  };

  logic [7:0]  frame_bytes [FRAME_LEN];
  int unsigned rx_pos;
  chan_word_t  pending_words [$];

  int          idle_pct;
  int          stall_pct;
  int unsigned err_count;
  int unsigned items_used;
  int unsigned words_checked;
  int unsigned frames_good;
  int unsigned frames_bad;
  int unsigned frames_cut;
  int unsigned bytes_ignored;
  int unsigned idle_cycles;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic signed [8:0] map_channel(input int c, input int raw);
    int in_lo;
    int in_hi;
    int out_lo;
    int out_hi;
    int val;
    in_lo  = 306;
    in_hi  = 1694;
    out_lo = 0;
    out_hi = 100;
    case (c)
      0: begin in_lo = 314; in_hi = 1690; out_lo = -20;  out_hi = 20;  end
      1: begin in_hi = 1693; out_lo = -100; out_hi = 100; end
      2: begin in_hi = 1693; out_lo = -115; out_hi = 115; end
      3: begin in_lo = 302; out_lo = -100; out_hi = 100; end
      5: begin out_lo = -50; out_hi = 50; end
      8: begin in_lo = 292; in_hi = 1692; end
      default: ;
    endcase
    if (c >= SCALED_CH) return '0;
    val = (raw - in_lo) * (out_hi - out_lo) / (in_hi - in_lo) + out_lo;
    return val[8:0];
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic st, input bit keep);
    logic [8*PAYLOAD_BYTES-1:0] payload;
    chan_word_t w;
    if (st) rx_pos = 0;
    if (rx_pos >= FRAME_LEN) begin
      bytes_ignored++;
      return;
    end
    items_used++;
    frame_bytes[rx_pos] = b;
    rx_pos++;
    if (rx_pos < FRAME_LEN) return;
    if (frame_bytes[0] != HEADER_BYTE || frame_bytes[FRAME_LEN-1] != FOOTER_BYTE) begin
      frames_bad++;
      w = '0;
      w.last = 1'b1;
      if (keep) pending_words.push_back(w);
      return;
    end
    frames_good++;
    for (int i = 0; i < PAYLOAD_BYTES; i++) payload[i*8 +: 8] = frame_bytes[i+1];
    for (int c = 0; c < NUM_CH; c++) begin
      w.ch     = c[3:0];
      w.raw    = payload[c*11 +: 11];
      w.scaled = map_channel(c, int'(w.raw));
      w.lost   = frame_bytes[FLAGS_POS][LOST_BIT];
      w.fs     = frame_bytes[FLAGS_POS][FAILSAFE_BIT];
      w.ok     = 1'b1;
      w.last   = (c == NUM_CH - 1);
      if (keep) pending_words.push_back(w);
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic st, input bit keep);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= st;
    do @(posedge clk); while (!s_axis_tready);
    decode_byte(b, st, keep);
  endtask

  task automatic send_frame(input frame_row_t r);
    logic [7:0] b;
    for (int i = 0; i < r.len; i++) begin
      if (i == 0) b = r.hdr;
      else if (i == FRAME_LEN - 1) b = r.ftr;
      else if (i == FLAGS_POS) b = r.flags;
      else if (r.rand_fill) b = 8'($urandom_range(0, 255));
      else b = r.fill;
      send_byte(b, (i == 0) ? r.first_start : 1'b0, !r.typed_bad);
    end
    if (r.typed_bad)
      pending_words.push_back('{ch: 4'd0, raw: 11'd0, scaled: 9'sd0, lost: 1'b0,
                                fs: 1'b0, ok: 1'b0, last: 1'b1});
    if (r.len < FRAME_LEN) frames_cut++;
    for (int i = 0; i < r.trail; i++) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  function automatic frame_row_t random_frame();
    frame_row_t r;
    int pick;
    int fill_mode;
    r.hdr         = HEADER_BYTE;
    r.ftr         = FOOTER_BYTE;
    r.flags       = 8'($urandom_range(0, 255));
    r.len         = FRAME_LEN;
    r.first_start = 1'b1;
    r.trail       = 0;
    r.typed_bad   = 1'b0;
    pick          = $urandom_range(0, 99);
    fill_mode     = $urandom_range(0, 9);
    r.rand_fill   = (fill_mode > 1);
    r.fill        = (fill_mode == 1) ? 8'hFF : 8'h00;
    if (pick < 12) begin
      do r.hdr = 8'($urandom_range(0, 255)); while (r.hdr == HEADER_BYTE);
    end else if (pick < 24) begin
      r.ftr = 8'($urandom_range(1, 255));
    end else if (pick < 32) begin
      r.len = $urandom_range(1, FRAME_LEN - 1);
    end
    if ($urandom_range(0, 9) == 0) r.trail = $urandom_range(1, 4);
    return r;
  endfunction

  task automatic drain_words();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin : result_check
    chan_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: tdata 0x%08h tlast %0b", m_axis_tdata, m_axis_tlast);
        err_count++;
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        check_field("channel_index", want.ch, m_axis_tdata[3:0]);
        check_field("raw_value", want.raw, m_axis_tdata[14:4]);
        check_field("scaled_value", want.scaled, $signed(m_axis_tdata[23:15]));
        check_field("lost_frame", want.lost, m_axis_tdata[24]);
        check_field("failsafe", want.fs, m_axis_tdata[25]);
        check_field("frame_ok", want.ok, m_axis_tdata[26]);
        check_field("last", want.last, m_axis_tlast);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned base;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    m_axis_tready <= 1'b0;
    idle_cycles   = 0;
    idle_pct      = 0;
    stall_pct     = 0;
    err_count     = 0;
    items_used    = 0;
    words_checked = 0;
    frames_good   = 0;
    frames_bad    = 0;
    frames_cut    = 0;
    bytes_ignored = 0;
    rx_pos        = 0;
    for (int i = 0; i < FRAME_LEN; i++) frame_bytes[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_frame(dir_rows[i]);

    base = items_used;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase
      // hold the sender until the decoder has emptied out
      drain_words();
      while (items_used < base + (ph + 1) * PHASE_ITEMS) send_frame(random_frame());
    end

    drain_words();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_words.size() != 0) begin
      $error("%0d expected words never arrived", pending_words.size());
      err_count += pending_words.size();
    end
    $display("Sent %0d frame bytes (%0d ignored past frame end): %0d good, %0d bad, %0d cut",
             items_used + bytes_ignored, bytes_ignored, frames_good, frames_bad, frames_cut);
    $display("Checked %0d output words, %0d failures", words_checked, err_count);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
